/* src/aes_pkg.sv */
// aes_pkg: shared types, constants and gf(2^8) helper functions for the aes-128 block
// no dependencies
`default_nettype none
package aes_pkg;
   localparam int unsigned NumRounds = 10;
   localparam int unsigned RoundWidth = $clog2(NumRounds + 1);
   localparam int unsigned HalfWidth = 64;
   localparam int unsigned BlockWidth = 128;
   localparam int unsigned CsrIndexWidth = 1;

   typedef enum logic [CsrIndexWidth-1:0] {
      CSR_KEY_HIGH = 1'b0,
      CSR_KEY_LOW  = 1'b1
   } csr_index_type;

   typedef enum logic {
      CMD_ENCRYPT = 1'b0,
      CMD_DECRYPT = 1'b1
   } command_type;

   typedef logic [7:0] byte_type;
   typedef logic [BlockWidth-1:0] block_type;

   function automatic byte_type xt(input byte_type a);
      xt = {a[6:0], 1'b0} ^ (a[7] ? 8'h1b : 8'h00);
   endfunction

   function automatic byte_type sbox(input byte_type a);
      byte_type tab [256];
      tab = '{
         8'h63,8'h7c,8'h77,8'h7b,8'hf2,8'h6b,8'h6f,8'hc5,8'h30,8'h01,8'h67,8'h2b,8'hfe,8'hd7,8'hab,8'h76,
         8'hca,8'h82,8'hc9,8'h7d,8'hfa,8'h59,8'h47,8'hf0,8'had,8'hd4,8'ha2,8'haf,8'h9c,8'ha4,8'h72,8'hc0,
         8'hb7,8'hfd,8'h93,8'h26,8'h36,8'h3f,8'hf7,8'hcc,8'h34,8'ha5,8'he5,8'hf1,8'h71,8'hd8,8'h31,8'h15,
         8'h04,8'hc7,8'h23,8'hc3,8'h18,8'h96,8'h05,8'h9a,8'h07,8'h12,8'h80,8'he2,8'heb,8'h27,8'hb2,8'h75,
         8'h09,8'h83,8'h2c,8'h1a,8'h1b,8'h6e,8'h5a,8'ha0,8'h52,8'h3b,8'hd6,8'hb3,8'h29,8'he3,8'h2f,8'h84,
         8'h53,8'hd1,8'h00,8'hed,8'h20,8'hfc,8'hb1,8'h5b,8'h6a,8'hcb,8'hbe,8'h39,8'h4a,8'h4c,8'h58,8'hcf,
         8'hd0,8'hef,8'haa,8'hfb,8'h43,8'h4d,8'h33,8'h85,8'h45,8'hf9,8'h02,8'h7f,8'h50,8'h3c,8'h9f,8'ha8,
         8'h51,8'ha3,8'h40,8'h8f,8'h92,8'h9d,8'h38,8'hf5,8'hbc,8'hb6,8'hda,8'h21,8'h10,8'hff,8'hf3,8'hd2,
         8'hcd,8'h0c,8'h13,8'hec,8'h5f,8'h97,8'h44,8'h17,8'hc4,8'ha7,8'h7e,8'h3d,8'h64,8'h5d,8'h19,8'h73,
         8'h60,8'h81,8'h4f,8'hdc,8'h22,8'h2a,8'h90,8'h88,8'h46,8'hee,8'hb8,8'h14,8'hde,8'h5e,8'h0b,8'hdb,
         8'he0,8'h32,8'h3a,8'h0a,8'h49,8'h06,8'h24,8'h5c,8'hc2,8'hd3,8'hac,8'h62,8'h91,8'h95,8'he4,8'h79,
         8'he7,8'hc8,8'h37,8'h6d,8'h8d,8'hd5,8'h4e,8'ha9,8'h6c,8'h56,8'hf4,8'hea,8'h65,8'h7a,8'hae,8'h08,
         8'hba,8'h78,8'h25,8'h2e,8'h1c,8'ha6,8'hb4,8'hc6,8'he8,8'hdd,8'h74,8'h1f,8'h4b,8'hbd,8'h8b,8'h8a,
         8'h70,8'h3e,8'hb5,8'h66,8'h48,8'h03,8'hf6,8'h0e,8'h61,8'h35,8'h57,8'hb9,8'h86,8'hc1,8'h1d,8'h9e,
         8'he1,8'hf8,8'h98,8'h11,8'h69,8'hd9,8'h8e,8'h94,8'h9b,8'h1e,8'h87,8'he9,8'hce,8'h55,8'h28,8'hdf,
         8'h8c,8'ha1,8'h89,8'h0d,8'hbf,8'he6,8'h42,8'h68,8'h41,8'h99,8'h2d,8'h0f,8'hb0,8'h54,8'hbb,8'h16};
      sbox = tab[a];
   endfunction

   function automatic byte_type inv_sbox(input byte_type a);
      byte_type tab [256];
      tab = '{
         8'h52,8'h09,8'h6a,8'hd5,8'h30,8'h36,8'ha5,8'h38,8'hbf,8'h40,8'ha3,8'h9e,8'h81,8'hf3,8'hd7,8'hfb,
         8'h7c,8'he3,8'h39,8'h82,8'h9b,8'h2f,8'hff,8'h87,8'h34,8'h8e,8'h43,8'h44,8'hc4,8'hde,8'he9,8'hcb,
         8'h54,8'h7b,8'h94,8'h32,8'ha6,8'hc2,8'h23,8'h3d,8'hee,8'h4c,8'h95,8'h0b,8'h42,8'hfa,8'hc3,8'h4e,
         8'h08,8'h2e,8'ha1,8'h66,8'h28,8'hd9,8'h24,8'hb2,8'h76,8'h5b,8'ha2,8'h49,8'h6d,8'h8b,8'hd1,8'h25,
         8'h72,8'hf8,8'hf6,8'h64,8'h86,8'h68,8'h98,8'h16,8'hd4,8'ha4,8'h5c,8'hcc,8'h5d,8'h65,8'hb6,8'h92,
         8'h6c,8'h70,8'h48,8'h50,8'hfd,8'hed,8'hb9,8'hda,8'h5e,8'h15,8'h46,8'h57,8'ha7,8'h8d,8'h9d,8'h84,
         8'h90,8'hd8,8'hab,8'h00,8'h8c,8'hbc,8'hd3,8'h0a,8'hf7,8'he4,8'h58,8'h05,8'hb8,8'hb3,8'h45,8'h06,
         8'hd0,8'h2c,8'h1e,8'h8f,8'hca,8'h3f,8'h0f,8'h02,8'hc1,8'haf,8'hbd,8'h03,8'h01,8'h13,8'h8a,8'h6b,
         8'h3a,8'h91,8'h11,8'h41,8'h4f,8'h67,8'hdc,8'hea,8'h97,8'hf2,8'hcf,8'hce,8'hf0,8'hb4,8'he6,8'h73,
         8'h96,8'hac,8'h74,8'h22,8'he7,8'had,8'h35,8'h85,8'he2,8'hf9,8'h37,8'he8,8'h1c,8'h75,8'hdf,8'h6e,
         8'h47,8'hf1,8'h1a,8'h71,8'h1d,8'h29,8'hc5,8'h89,8'h6f,8'hb7,8'h62,8'h0e,8'haa,8'h18,8'hbe,8'h1b,
         8'hfc,8'h56,8'h3e,8'h4b,8'hc6,8'hd2,8'h79,8'h20,8'h9a,8'hdb,8'hc0,8'hfe,8'h78,8'hcd,8'h5a,8'hf4,
         8'h1f,8'hdd,8'ha8,8'h33,8'h88,8'h07,8'hc7,8'h31,8'hb1,8'h12,8'h10,8'h59,8'h27,8'h80,8'hec,8'h5f,
         8'h60,8'h51,8'h7f,8'ha9,8'h19,8'hb5,8'h4a,8'h0d,8'h2d,8'he5,8'h7a,8'h9f,8'h93,8'hc9,8'h9c,8'hef,
         8'ha0,8'he0,8'h3b,8'h4d,8'hae,8'h2a,8'hf5,8'hb0,8'hc8,8'heb,8'hbb,8'h3c,8'h83,8'h53,8'h99,8'h61,
         8'h17,8'h2b,8'h04,8'h7e,8'hba,8'h77,8'hd6,8'h26,8'he1,8'h69,8'h14,8'h63,8'h55,8'h21,8'h0c,8'h7d};
      inv_sbox = tab[a];
   endfunction

   // byte i of a block sits at bits 127-8i downto 120-8i
   function automatic byte_type get_byte(input block_type b, input int unsigned i);
      get_byte = b[BlockWidth-1-8*i -: 8];
   endfunction

   function automatic block_type sub_shift(input block_type s);
      block_type t;
      for (int r = 0; r < 4; r++) begin
         for (int c = 0; c < 4; c++) begin
            t[BlockWidth-1-8*(r+4*c) -: 8] = sbox(get_byte(s, r + 4*((c + r) % 4)));
         end
      end
      sub_shift = t;
   endfunction

   function automatic block_type inv_shift_sub(input block_type s);
      block_type t;
      for (int r = 0; r < 4; r++) begin
         for (int c = 0; c < 4; c++) begin
            t[BlockWidth-1-8*(r+4*((c + r) % 4)) -: 8] = inv_sbox(get_byte(s, r + 4*c));
         end
      end
      inv_shift_sub = t;
   endfunction

   function automatic block_type mix_cols(input block_type s);
      block_type t;
      byte_type a0, a1, a2, a3;
      for (int c = 0; c < 4; c++) begin
         a0 = get_byte(s, 4*c);
         a1 = get_byte(s, 4*c+1);
         a2 = get_byte(s, 4*c+2);
         a3 = get_byte(s, 4*c+3);
         t[BlockWidth-1-8*(4*c)   -: 8] = xt(a0) ^ xt(a1) ^ a1 ^ a2 ^ a3;
         t[BlockWidth-1-8*(4*c+1) -: 8] = a0 ^ xt(a1) ^ xt(a2) ^ a2 ^ a3;
         t[BlockWidth-1-8*(4*c+2) -: 8] = a0 ^ a1 ^ xt(a2) ^ xt(a3) ^ a3;
         t[BlockWidth-1-8*(4*c+3) -: 8] = xt(a0) ^ a0 ^ a1 ^ a2 ^ xt(a3);
      end
      mix_cols = t;
   endfunction

   // inverse mix as a pre-multiply by {04,05} pattern followed by the forward mix
   function automatic block_type inv_mix_cols(input block_type s);
      block_type t;
      byte_type u, v;
      for (int c = 0; c < 4; c++) begin
         u = xt(xt(get_byte(s, 4*c) ^ get_byte(s, 4*c+2)));
         v = xt(xt(get_byte(s, 4*c+1) ^ get_byte(s, 4*c+3)));
         t[BlockWidth-1-8*(4*c)   -: 8] = get_byte(s, 4*c) ^ u;
         t[BlockWidth-1-8*(4*c+1) -: 8] = get_byte(s, 4*c+1) ^ v;
         t[BlockWidth-1-8*(4*c+2) -: 8] = get_byte(s, 4*c+2) ^ u;
         t[BlockWidth-1-8*(4*c+3) -: 8] = get_byte(s, 4*c+3) ^ v;
      end
      inv_mix_cols = mix_cols(t);
   endfunction

   // next round key, forward direction
   function automatic block_type key_fwd(input block_type k, input byte_type rc);
      block_type n;
      logic [31:0] w;
      w = {sbox(k[23:16]) ^ rc, sbox(k[15:8]), sbox(k[7:0]), sbox(k[31:24])};
      n[127:96] = k[127:96] ^ w;
      n[95:64]  = k[95:64] ^ n[127:96];
      n[63:32]  = k[63:32] ^ n[95:64];
      n[31:0]   = k[31:0] ^ n[63:32];
      key_fwd = n;
   endfunction

   // previous round key, rc is that of the step being undone
   function automatic block_type key_bwd(input block_type k, input byte_type rc);
      block_type p;
      logic [31:0] w;
      p[31:0]  = k[31:0] ^ k[63:32];
      p[63:32] = k[63:32] ^ k[95:64];
      p[95:64] = k[95:64] ^ k[127:96];
      w = {sbox(p[23:16]) ^ rc, sbox(p[15:8]), sbox(p[7:0]), sbox(p[31:24])};
      p[127:96] = k[127:96] ^ w;
      key_bwd = p;
   endfunction

   function automatic byte_type inv_xt(input byte_type a);
      inv_xt = a[0] ? ({1'b1, a[7:1]} ^ 8'h0d) : {1'b0, a[7:1]};
   endfunction
endpackage
`default_nettype wire

/* src/aes_stream_if.sv */
// aes_stream_if: valid/ready channel carrying a payload of a given type
// depends on nothing; payload type set by the instantiating level
`default_nettype none
interface aes_stream_if #(parameter type payload_type = logic) (input wire logic clock);
   logic        valid;
   logic        ready;
   payload_type payload;
   modport source (output valid, output payload, input ready);
   modport sink (input valid, input payload, output ready);
endinterface
`default_nettype wire

/* src/aes128_block_cipher_top.sv */
// aes-128 block cipher top level: iterative round unit with on-the-fly key schedule
// depends on aes_pkg
// encrypt runs one round per cycle between request transfer and result valid
// a new block is accepted only once the result of the last one has been taken, as the
// single shared round unit and the result and idle states serve one block at a time
// decryption first walks the key schedule forward to the last round key, then runs the inverse rounds
// reset: synchronous active high; clears control and the key registers to zero
`default_nettype none
module aes128_block_cipher_top
   import aes_pkg::*;
(
   input  wire logic                     clock,
   input  wire logic                     reset,
   input  wire logic                     req_valid,
   output logic                          req_ready,
   input  wire logic                     req_command,
   input  wire logic [HalfWidth-1:0]     req_block_high,
   input  wire logic [HalfWidth-1:0]     req_block_low,
   output logic                          rsp_valid,
   input  wire logic                     rsp_ready,
   output logic [HalfWidth-1:0]          rsp_result_high,
   output logic [HalfWidth-1:0]          rsp_result_low,
   input  wire logic                     csr_write,
   input  wire logic [CsrIndexWidth-1:0] csr_index,
   input  wire logic [HalfWidth-1:0]     csr_data
);
   typedef enum logic [1:0] {
      ST_IDLE, ST_KEYWALK, ST_ROUND, ST_DONE
   } state_type;

   state_type             state_ff;
   logic [HalfWidth-1:0]  key_high_ff, key_low_ff;
   block_type             data_ff, data_in;
   block_type             rkey_ff, rkey_in;
   byte_type              rcon_ff, rcon_in;
   logic [RoundWidth-1:0] round_ff;
   logic                  decrypt_ff;
   block_type             master_key;
   logic                  req_xfer, rsp_xfer;

   assign master_key = {key_high_ff, key_low_ff};
   assign req_ready = (state_ff == ST_IDLE);
   assign rsp_valid = (state_ff == ST_DONE);
   assign req_xfer = req_valid && req_ready;
   assign rsp_xfer = rsp_valid && rsp_ready;
   assign rsp_result_high = data_ff[BlockWidth-1 -: HalfWidth];
   assign rsp_result_low  = data_ff[HalfWidth-1:0];

   // shared round unit: one forward or inverse round plus key step, or a key walk step, per cycle
   always_comb begin
      data_in = data_ff;
      rkey_in = rkey_ff;
      rcon_in = rcon_ff;
      if (state_ff == ST_KEYWALK) begin
         rkey_in = key_fwd(rkey_ff, rcon_ff);
         // keep the last constant, the inverse walk starts by undoing that step
         rcon_in = (round_ff == RoundWidth'(NumRounds - 1)) ? rcon_ff : xt(rcon_ff);
         if (round_ff == RoundWidth'(NumRounds - 1)) begin
            data_in = data_ff ^ rkey_in;
         end
      end else if (!decrypt_ff) begin
         rkey_in = key_fwd(rkey_ff, rcon_ff);
         rcon_in = xt(rcon_ff);
         if (round_ff == RoundWidth'(NumRounds - 1)) begin
            data_in = sub_shift(data_ff) ^ rkey_in;
         end else begin
            data_in = mix_cols(sub_shift(data_ff)) ^ rkey_in;
         end
      end else begin
         rkey_in = key_bwd(rkey_ff, rcon_ff);
         rcon_in = inv_xt(rcon_ff);
         if (round_ff == RoundWidth'(NumRounds - 1)) begin
            data_in = inv_shift_sub(data_ff) ^ rkey_in;
         end else begin
            data_in = inv_mix_cols(inv_shift_sub(data_ff) ^ rkey_in);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff    <= ST_IDLE;
         key_high_ff <= '0;
         key_low_ff  <= '0;
         round_ff    <= '0;
         decrypt_ff  <= 1'b0;
      end else begin
         if (csr_write) begin
            case (csr_index)
               CSR_KEY_HIGH: key_high_ff <= csr_data;
               CSR_KEY_LOW:  key_low_ff  <= csr_data;
               default: ;
            endcase
         end
         case (state_ff)
            ST_IDLE: begin
               if (req_xfer) begin
                  decrypt_ff <= (req_command == CMD_DECRYPT);
                  rkey_ff    <= master_key;
                  rcon_ff    <= 8'h01;
                  round_ff   <= '0;
                  if (req_command == CMD_DECRYPT) begin
                     data_ff  <= {req_block_high, req_block_low};
                     state_ff <= ST_KEYWALK;
                  end else begin
                     data_ff  <= {req_block_high, req_block_low} ^ master_key;
                     state_ff <= ST_ROUND;
                  end
               end
            end
            ST_KEYWALK: begin
               // walk to the last round key, then add it
               rkey_ff <= rkey_in;
               rcon_ff <= rcon_in;
               data_ff <= data_in;
               if (round_ff == RoundWidth'(NumRounds - 1)) begin
                  round_ff <= '0;
                  state_ff <= ST_ROUND;
               end else begin
                  round_ff <= round_ff + 1'b1;
               end
            end
            ST_ROUND: begin
               rkey_ff <= rkey_in;
               rcon_ff <= rcon_in;
               data_ff <= data_in;
               if (round_ff == RoundWidth'(NumRounds - 1)) begin
                  state_ff <= ST_DONE;
               end else begin
                  round_ff <= round_ff + 1'b1;
               end
            end
            ST_DONE: begin
               if (rsp_xfer) begin
                  state_ff <= ST_IDLE;
               end
            end
            default: state_ff <= ST_IDLE;
         endcase
      end
   end

`ifndef SYNTHESIS
   a_no_accept_busy: assert property (@(posedge clock) disable iff (reset)
      (state_ff != ST_IDLE) |-> !req_ready)
      else $error("request accepted while busy");
   a_result_held: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_ready) |=> (rsp_valid && $stable(data_ff)))
      else $error("result dropped under stall");
   a_round_bound: assert property (@(posedge clock) disable iff (reset)
      round_ff <= RoundWidth'(NumRounds - 1))
      else $error("round counter out of range");
`endif
endmodule
`default_nettype wire

/* bench/aes128_block_cipher_checker.sv */
// aes128_block_cipher_checker: watches the request, result and csr ports, predicts each block
// with an independent aes-128 model and compares; depends on aes_pkg
`timescale 1ns / 100ps
`default_nettype none
module aes128_block_cipher_checker
   import aes_pkg::*;
(
   input  wire logic                     clock,
   input  wire logic                     reset,
   input  wire logic                     req_valid,
   input  wire logic                     req_ready,
   input  wire logic [BlockWidth:0]      req_payload,
   input  wire logic                     rsp_valid,
   input  wire logic                     rsp_ready,
   input  wire logic [BlockWidth-1:0]    rsp_payload,
   input  wire logic                     csr_write,
   input  wire logic [CsrIndexWidth-1:0] csr_index,
   input  wire logic [HalfWidth-1:0]     csr_data,
   output int                            fail_count,
   output int                            pending
);
   logic [7:0]            fwd_sub [256];
   logic [7:0]            rev_sub [256];
   logic [HalfWidth-1:0]  key_hi_copy;
   logic [HalfWidth-1:0]  key_lo_copy;
   logic [BlockWidth-1:0] expected_blocks [$];

   function automatic logic [7:0] dbl(input logic [7:0] a);
      dbl = {a[6:0], 1'b0} ^ (a[7] ? 8'h1b : 8'h00);
   endfunction

   function automatic logic [7:0] gf_mul(input logic [7:0] a, input logic [7:0] b);
      logic [7:0] p;
      logic [7:0] x;
      p = 8'h00;
      x = a;
      for (int i = 0; i < 8; i++) begin
         if (b[i]) p = p ^ x;
         x = dbl(x);
      end
      gf_mul = p;
   endfunction

   function automatic logic [7:0] rol8(input logic [7:0] v, input int n);
      rol8 = (v << n) | (v >> (8 - n));
   endfunction

   initial begin
      logic [7:0] inv;
      logic [7:0] s;
      for (int a = 0; a < 256; a++) begin
         // inverse as a^254, zero maps to zero
         inv = 8'h01;
         for (int e = 0; e < 254; e++) inv = gf_mul(inv, a[7:0]);
         s = inv ^ rol8(inv, 1) ^ rol8(inv, 2) ^ rol8(inv, 3) ^ rol8(inv, 4) ^ 8'h63;
         fwd_sub[a] = s;
         rev_sub[s] = a[7:0];
      end
   end

   function automatic logic [BlockWidth-1:0] aes_transform(input command_type cmd,
         input logic [BlockWidth-1:0] key, input logic [BlockWidth-1:0] blk);
      logic [7:0] rk [176];
      logic [7:0] st [16];
      logic [7:0] tmp [16];
      logic [7:0] w [4];
      logic [7:0] f;
      logic [7:0] rc;
      logic [7:0] co [4];
      logic [BlockWidth-1:0] res;
      int rnd;
      rc = 8'h01;
      for (int i = 0; i < 16; i++) begin
         rk[i] = key[BlockWidth-1-8*i -: 8];
         st[i] = blk[BlockWidth-1-8*i -: 8];
      end
      for (int i = 4; i < 44; i++) begin
         for (int j = 0; j < 4; j++) w[j] = rk[4*(i-1)+j];
         if (i % 4 == 0) begin
            f = w[0];
            w[0] = fwd_sub[w[1]] ^ rc;
            w[1] = fwd_sub[w[2]];
            w[2] = fwd_sub[w[3]];
            w[3] = fwd_sub[f];
            rc = dbl(rc);
         end
         for (int j = 0; j < 4; j++) rk[4*i+j] = rk[4*(i-4)+j] ^ w[j];
      end
      if (cmd == CMD_ENCRYPT) begin
         for (int i = 0; i < 16; i++) st[i] = st[i] ^ rk[i];
         for (rnd = 1; rnd <= NumRounds; rnd++) begin
            for (int r = 0; r < 4; r++)
               for (int c = 0; c < 4; c++) tmp[r+4*c] = fwd_sub[st[r+4*((c+r)%4)]];
            st = tmp;
            if (rnd != NumRounds) begin
               for (int c = 0; c < 4; c++) begin
                  for (int r = 0; r < 4; r++) co[r] = st[4*c+r];
                  for (int r = 0; r < 4; r++)
                     st[4*c+r] = dbl(co[r]) ^ dbl(co[(r+1)%4]) ^ co[(r+1)%4]
                                 ^ co[(r+2)%4] ^ co[(r+3)%4];
               end
            end
            for (int i = 0; i < 16; i++) st[i] = st[i] ^ rk[16*rnd+i];
         end
      end else begin
         for (int i = 0; i < 16; i++) st[i] = st[i] ^ rk[16*NumRounds+i];
         for (rnd = NumRounds - 1; rnd >= 0; rnd--) begin
            for (int r = 0; r < 4; r++)
               for (int c = 0; c < 4; c++) tmp[r+4*((c+r)%4)] = rev_sub[st[r+4*c]];
            st = tmp;
            for (int i = 0; i < 16; i++) st[i] = st[i] ^ rk[16*rnd+i];
            if (rnd != 0) begin
               for (int c = 0; c < 4; c++) begin
                  for (int r = 0; r < 4; r++) co[r] = st[4*c+r];
                  for (int r = 0; r < 4; r++)
                     st[4*c+r] = gf_mul(8'h0e, co[r]) ^ gf_mul(8'h0b, co[(r+1)%4])
                                 ^ gf_mul(8'h0d, co[(r+2)%4]) ^ gf_mul(8'h09, co[(r+3)%4]);
               end
            end
         end
      end
      for (int i = 0; i < 16; i++) res[BlockWidth-1-8*i -: 8] = st[i];
      aes_transform = res;
   endfunction

   task automatic report(input string what, input logic [HalfWidth-1:0] want,
         input logic [HalfWidth-1:0] got);
      $display("mismatch %s: expected %h got %h at %0t", what, want, got, $realtime);
      fail_count = fail_count + 1;
   endtask

   initial begin
      fail_count = 0;
      pending = 0;
      key_hi_copy = '0;
      key_lo_copy = '0;
   end

   always @(posedge clock) begin
      logic [BlockWidth-1:0] want;
      if (reset) begin
         key_hi_copy = '0;
         key_lo_copy = '0;
      end else begin
         if (csr_write) begin
            if (csr_index == CSR_KEY_HIGH) key_hi_copy = csr_data;
            else if (csr_index == CSR_KEY_LOW) key_lo_copy = csr_data;
         end
         if (req_valid && req_ready)
            expected_blocks.push_back(aes_transform(command_type'(req_payload[BlockWidth]),
                  {key_hi_copy, key_lo_copy}, req_payload[BlockWidth-1:0]));
         if (rsp_valid && rsp_ready) begin
            if (expected_blocks.size() == 0) begin
               report("unexpected result", '0, rsp_payload[BlockWidth-1:HalfWidth]);
            end else begin
               want = expected_blocks.pop_front();
               if (want[BlockWidth-1:HalfWidth] !== rsp_payload[BlockWidth-1:HalfWidth])
                  report("result_high", want[BlockWidth-1:HalfWidth],
                         rsp_payload[BlockWidth-1:HalfWidth]);
               if (want[HalfWidth-1:0] !== rsp_payload[HalfWidth-1:0])
                  report("result_low", want[HalfWidth-1:0], rsp_payload[HalfWidth-1:0]);
            end
         end
      end
      pending = expected_blocks.size();
   end
endmodule
`default_nettype wire

/* bench/aes128_block_cipher_top_tb.sv */
// aes128_block_cipher_top_tb: drives blocks and key writes into the cipher under varying idle
// patterns and gives the verdict; depends on aes_pkg, aes_stream_if, the cipher top and the checker
`timescale 1ns / 100ps
`default_nettype none
module aes128_block_cipher_top_tb;
   import aes_pkg::*;

   localparam int CycleLimit = 900000;
   localparam int SettleCycles = 30;

   logic                     clock;
   logic                     reset;
   logic                     csr_write;
   logic [CsrIndexWidth-1:0] csr_index;
   logic [HalfWidth-1:0]     csr_data;
   int                       fail_count;
   int                       pending;
   int                       cycle_count;
   int                       send_idle;
   int                       recv_idle;

   aes_stream_if #(.payload_type(logic [BlockWidth:0]))   req_if (clock);
   aes_stream_if #(.payload_type(logic [BlockWidth-1:0])) rsp_if (clock);

   aes128_block_cipher_top DUT (
      .clock           (clock),
      .reset           (reset),
      .req_valid       (req_if.valid),
      .req_ready       (req_if.ready),
      .req_command     (req_if.payload[BlockWidth]),
      .req_block_high  (req_if.payload[BlockWidth-1:HalfWidth]),
      .req_block_low   (req_if.payload[HalfWidth-1:0]),
      .rsp_valid       (rsp_if.valid),
      .rsp_ready       (rsp_if.ready),
      .rsp_result_high (rsp_if.payload[BlockWidth-1:HalfWidth]),
      .rsp_result_low  (rsp_if.payload[HalfWidth-1:0]),
      .csr_write       (csr_write),
      .csr_index       (csr_index),
      .csr_data        (csr_data)
   );

   aes128_block_cipher_checker checker_i (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_if.valid),
      .req_ready   (req_if.ready),
      .req_payload (req_if.payload),
      .rsp_valid   (rsp_if.valid),
      .rsp_ready   (rsp_if.ready),
      .rsp_payload (rsp_if.payload),
      .csr_write   (csr_write),
      .csr_index   (csr_index),
      .csr_data    (csr_data),
      .fail_count  (fail_count),
      .pending     (pending)
   );

   always begin
      clock = 1'b1;
      #5;
      clock = 1'b0;
      #5;
   end

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= CycleLimit) begin
         $display("** aes128_block_cipher_top: FAILED **");
         $finish;
      end
   end

   always @(negedge clock) begin
      if (reset) rsp_if.ready <= 1'b0;
      else rsp_if.ready <= ($urandom_range(99) >= recv_idle);
   end

   function automatic logic [HalfWidth-1:0] rand_half();
      logic [HalfWidth-1:0] v;
      case ($urandom_range(7))
         0: v = '0;
         1: v = '1;
         2: v = {{HalfWidth-1{1'b0}}, 1'b1} << $urandom_range(HalfWidth-1);
         default: v = {$urandom, $urandom};
      endcase
      return v;
   endfunction

   task automatic send_block(input command_type cmd, input logic [HalfWidth-1:0] hi,
         input logic [HalfWidth-1:0] lo);
      while ($urandom_range(99) < send_idle) begin
         req_if.valid = 1'b0;
         @(negedge clock);
      end
      req_if.valid = 1'b1;
      req_if.payload = {cmd, hi, lo};
      do @(posedge clock); while (!req_if.ready);
      @(negedge clock);
   endtask

   // key may only change with the core drained; decrypt runs longest
   task automatic load_key(input logic [HalfWidth-1:0] hi, input logic [HalfWidth-1:0] lo);
      req_if.valid = 1'b0;
      while (pending != 0) @(negedge clock);
      repeat (SettleCycles) @(negedge clock);
      csr_write = 1'b1;
      csr_index = CSR_KEY_HIGH;
      csr_data = hi;
      @(negedge clock);
      csr_index = CSR_KEY_LOW;
      csr_data = lo;
      @(negedge clock);
      csr_write = 1'b0;
   endtask

   initial begin
      logic [BlockWidth-1:0] ct;
      cycle_count = 0;
      reset = 1'b1;
      req_if.valid = 1'b0;
      req_if.payload = '0;
      rsp_if.ready = 1'b0;
      csr_write = 1'b0;
      csr_index = CSR_KEY_HIGH;
      csr_data = '0;
      send_idle = 35;
      recv_idle = 66;
      repeat (7) @(negedge clock);
      reset = 1'b0;

      // reset key of all zeros before any write
      send_block(CMD_ENCRYPT, '0, '0);
      send_block(CMD_DECRYPT, '0, '0);
      send_block(CMD_ENCRYPT, '1, '1);
      send_block(CMD_DECRYPT, '1, '1);
      // standard known-answer vector, both directions
      load_key(64'h0001020304050607, 64'h08090a0b0c0d0e0f);
      send_block(CMD_ENCRYPT, 64'h0011223344556677, 64'h8899aabbccddeeff);
      send_block(CMD_DECRYPT, 64'h69c4e0d86a7b0430, 64'hd8cdb78070b4c55a);
      send_block(CMD_ENCRYPT, '0, '1);
      send_block(CMD_DECRYPT, '1, '0);
      load_key('1, '1);
      send_block(CMD_ENCRYPT, '0, '0);
      send_block(CMD_DECRYPT, '0, '0);
      send_block(CMD_ENCRYPT, '1, '1);
      send_block(CMD_DECRYPT, 64'h8000000000000000, 64'h0000000000000001);

      for (int phase = 0; phase < 3; phase++) begin
         send_idle = (phase == 0) ? 35 : (phase == 1) ? 66 : 0;
         recv_idle = (phase == 0) ? 66 : (phase == 1) ? 35 : 0;
         for (int seg = 0; seg < 4; seg++) begin
            case (seg)
               0: load_key(rand_half(), rand_half());
               1: load_key('0, rand_half());
               2: load_key(rand_half(), '1);
               default: load_key({$urandom, $urandom}, {$urandom, $urandom});
            endcase
            for (int n = 0; n < 120; n++) begin
               ct = {rand_half(), rand_half()};
               send_block(command_type'($urandom_range(1)), ct[BlockWidth-1:HalfWidth],
                          ct[HalfWidth-1:0]);
            end
         end
      end

      req_if.valid = 1'b0;
      while (pending != 0) @(negedge clock);
      repeat (SettleCycles) @(negedge clock);
      if (fail_count == 0 && pending == 0) begin
         $display("** aes128_block_cipher_top: PASSED **");
      end else begin
         $display("** aes128_block_cipher_top: FAILED **");
      end
      $finish;
   end
endmodule
`default_nettype wire
